>>> rtl/bibe_pkg.sv
// Shared types and constants for the binary image border extractor.
`default_nettype none
package bibe_pkg;

    // Fixed field widths that follow from the configuration registers.
    localparam int CW  = 9;   // x and y coordinates, width and height
    localparam int ZW  = 16;  // plane coordinate and plane count
    localparam int PW  = 18;  // position inside one plane
    localparam int DLW = 19;  // window delay in items

    // Output queue depth, its address width and its counter width.
    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = 3;
    localparam int OQ_CW    = 4;

    // Operating modes.
    localparam logic [2:0] MODE_BIN4  = 3'd0;
    localparam logic [2:0] MODE_BIN8  = 3'd1;
    localparam logic [2:0] MODE_3D6   = 3'd2;
    localparam logic [2:0] MODE_3D26  = 3'd3;
    localparam logic [2:0] MODE_LAB4  = 3'd4;
    localparam logic [2:0] MODE_LAB8  = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_PLANES = 2'd3;

    localparam logic [31:0] LABEL_EDGE = 32'd255;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic        flush;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic        last;
    } t_out_item;

    // Geometry derived from the configuration registers.
    typedef struct packed {
        logic [2:0]     mode;
        logic           is3d;
        logic [CW-1:0]  w;
        logic [CW-1:0]  h;
        logic [ZW-1:0]  d;
        logic [PW-1:0]  ps;
        logic [DLW-1:0] delay;
    } t_geom;

    // One window advance travelling through the pipeline.
    typedef struct packed {
        logic          valid;
        logic          emit;
        logic          last;
        logic [31:0]   pix;
        logic [CW-1:0] raddr;
        logic [PW-1:0] paddr;
        logic [CW-1:0] xc;
        logic [CW-1:0] yc;
        logic [ZW-1:0] zc;
    } t_adv;

    // Row buffer word: two delayed rows for each of the three plane streams.
    typedef struct packed {
        logic [31:0] s0r1;
        logic [31:0] s0r2;
        logic [7:0]  s1r1;
        logic [7:0]  s1r2;
        logic [7:0]  s2r1;
        logic [7:0]  s2r2;
    } t_row_word;

endpackage
`default_nettype wire

>>> rtl/bibe_ctrl.sv
// Sequencer: position counters, window priming and issue of window advances.
`default_nettype none
module bibe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  bibe_pkg::t_in_item i_item,
    input  bibe_pkg::t_geom   i_geom,
    input  logic              i_credit,
    input  logic              i_cfg_wait,
    output bibe_pkg::t_adv    o_adv
);
    import bibe_pkg::*;

    typedef enum logic {ST_RUN, ST_FILL} t_state;

    t_state         r_state, n_state;
    logic           r_done, n_done;
    logic           r_primed, n_primed;
    logic [DLW-1:0] r_adv_cnt, n_adv_cnt;
    logic [CW-1:0]  r_xi, n_xi, r_yi, n_yi, r_xc, n_xc, r_yc, n_yc, r_xe, n_xe;
    logic [ZW-1:0]  r_zi, n_zi, r_zc, n_zc;
    logic [PW-1:0]  r_pa, n_pa;
    t_adv           r_adv, n_adv;

    logic accept, store, do_adv, primed_after, emit, done_after, in_last, c_last;

    assign o_stall = i_cfg_wait || (r_state == ST_FILL) || !i_credit;
    assign o_adv   = r_adv;

    // Decide what this cycle does to the window and the counters.
    always_comb begin
        accept       = i_valid && !o_stall;
        store        = accept && !i_item.flush && !r_done;
        in_last      = (r_xi == i_geom.w - 9'd1) && (r_yi == i_geom.h - 9'd1) &&
                       (r_zi == i_geom.d - 16'd1);
        c_last       = (r_xc == i_geom.w - 9'd1) && (r_yc == i_geom.h - 9'd1) &&
                       (r_zc == i_geom.d - 16'd1);
        do_adv       = (accept && (store || r_done)) ||
                       ((r_state == ST_FILL) && i_credit && !i_cfg_wait);
        primed_after = r_primed || (r_adv_cnt == i_geom.delay);
        emit         = do_adv && primed_after;
        done_after   = r_done || (store && in_last);

        n_state   = r_state;
        n_done    = done_after;
        n_primed  = r_primed;
        n_adv_cnt = r_adv_cnt;
        n_xi = r_xi; n_yi = r_yi; n_zi = r_zi;
        n_xc = r_xc; n_yc = r_yc; n_zc = r_zc;
        n_xe = r_xe; n_pa = r_pa;

        // Input position advances on every stored pixel.
        if (store) begin
            if (r_xi == i_geom.w - 9'd1) begin
                n_xi = '0;
                if (r_yi == i_geom.h - 9'd1) begin
                    n_yi = '0;
                    n_zi = r_zi + 16'd1;
                end else begin
                    n_yi = r_yi + 9'd1;
                end
            end else begin
                n_xi = r_xi + 9'd1;
            end
        end

        // Each advance moves the row and plane buffer addresses.
        if (do_adv) begin
            n_xe = (r_xe == i_geom.w - 9'd1) ? '0 : r_xe + 9'd1;
            n_pa = (r_pa == i_geom.ps - 18'd1) ? '0 : r_pa + 18'd1;
            n_primed = primed_after;
            if (!primed_after) begin
                n_adv_cnt = r_adv_cnt + 19'd1;
            end
            n_state = (!emit && done_after) ? ST_FILL : ST_RUN;
        end

        // The centre moves on with each result; the last one restarts the image.
        if (emit) begin
            if (c_last) begin
                n_state = ST_RUN;
                n_done = 1'b0; n_primed = 1'b0; n_adv_cnt = '0;
                n_xi = '0; n_yi = '0; n_zi = '0;
                n_xc = '0; n_yc = '0; n_zc = '0;
                n_xe = '0; n_pa = '0;
            end else if (r_xc == i_geom.w - 9'd1) begin
                n_xc = '0;
                if (r_yc == i_geom.h - 9'd1) begin
                    n_yc = '0;
                    n_zc = r_zc + 16'd1;
                end else begin
                    n_yc = r_yc + 9'd1;
                end
            end else begin
                n_xc = r_xc + 9'd1;
            end
        end

        n_adv.valid = do_adv;
        n_adv.emit  = emit;
        n_adv.last  = emit && c_last;
        n_adv.pix   = store ? i_item.pixel_value : 32'd0;
        n_adv.raddr = r_xe;
        n_adv.paddr = r_pa;
        n_adv.xc    = r_xc;
        n_adv.yc    = r_yc;
        n_adv.zc    = r_zc;
    end

    // State, counters and the issued advance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_done <= 1'b0; r_primed <= 1'b0; r_adv_cnt <= '0;
            r_xi <= '0; r_yi <= '0; r_zi <= '0;
            r_xc <= '0; r_yc <= '0; r_zc <= '0;
            r_xe <= '0; r_pa <= '0;
            r_adv <= '0;
        end else begin
            r_state <= n_state;
            r_done <= n_done; r_primed <= n_primed; r_adv_cnt <= n_adv_cnt;
            r_xi <= n_xi; r_yi <= n_yi; r_zi <= n_zi;
            r_xc <= n_xc; r_yc <= n_yc; r_zc <= n_zc;
            r_xe <= n_xe; r_pa <= n_pa;
            r_adv <= n_adv;
        end
    end

endmodule
`default_nettype wire

>>> rtl/bibe_window.sv
// Row and plane buffers, the 3x3x3 window and the border decision.
`default_nettype none
module bibe_window #(
    parameter int ROW_DEPTH = 256,
    parameter int PL_DEPTH  = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bibe_pkg::t_geom     i_geom,
    input  bibe_pkg::t_adv      i_adv,
    output logic                o_res_valid,
    output bibe_pkg::t_out_item o_res,
    output logic [1:0]          o_pend
);
    import bibe_pkg::*;

    localparam int RAW = $clog2(ROW_DEPTH);
    localparam int PAW = $clog2(PL_DEPTH);

    t_row_word   row_mem [ROW_DEPTH];
    logic [15:0] pl_mem  [PL_DEPTH];

    t_row_word   r_row_rd, r_row_fwd_d, row_word, row_wd;
    logic [15:0] r_pl_rd, r_pl_fwd_d, pl_word, pl_wd;
    logic        r_row_fwd, r_pl_fwd;
    t_adv        r_s2, r_s3;

    // Window taps [row][col]: plane z+1 (or the 2D plane) in 32 bits, z and z-1 in bytes.
    logic [31:0] r_w0 [3][3];
    logic [7:0]  r_b1 [3][3];
    logic [7:0]  r_b0 [3][3];

    logic [7:0]  s1v, s2v;
    logic [2:0]  okx, oky, okz;
    logic [7:0]  cube [3][3][3];
    logic        bg8, bg4, bg26, bg6, df8, df4, face;
    logic [7:0]  cb2, cb3;

    // Forwarded data covers a read of the entry written at the same edge.
    always_comb begin
        row_word = r_row_fwd ? r_row_fwd_d : r_row_rd;
        pl_word  = r_pl_fwd ? r_pl_fwd_d : r_pl_rd;
        s1v      = pl_word[7:0];
        s2v      = pl_word[15:8];
        pl_wd    = {pl_word[7:0], r_s2.pix[7:0]};
        row_wd.s0r1 = r_s2.pix;
        row_wd.s0r2 = row_word.s0r1;
        row_wd.s1r1 = s1v;
        row_wd.s1r2 = row_word.s1r1;
        row_wd.s2r1 = s2v;
        row_wd.s2r2 = row_word.s2r1;
    end

    // Buffer read, write back, window shift, stage valids and forwarding flags.
    always_ff @(posedge i_clk) begin
        r_row_rd <= row_mem[i_adv.raddr[RAW-1:0]];
        r_pl_rd  <= pl_mem[i_adv.paddr[PAW-1:0]];
        r_row_fwd_d <= row_wd;
        r_pl_fwd_d  <= pl_wd;
        if (r_s2.valid) begin
            row_mem[r_s2.raddr[RAW-1:0]] <= row_wd;
            pl_mem[r_s2.paddr[PAW-1:0]]  <= pl_wd;
            for (int r = 0; r < 3; r++) begin
                r_w0[r][0] <= r_w0[r][1]; r_w0[r][1] <= r_w0[r][2];
                r_b1[r][0] <= r_b1[r][1]; r_b1[r][1] <= r_b1[r][2];
                r_b0[r][0] <= r_b0[r][1]; r_b0[r][1] <= r_b0[r][2];
            end
            r_w0[2][2] <= r_s2.pix;
            r_w0[1][2] <= row_word.s0r1;
            r_w0[0][2] <= row_word.s0r2;
            r_b1[2][2] <= s1v;
            r_b1[1][2] <= row_word.s1r1;
            r_b1[0][2] <= row_word.s1r2;
            r_b0[2][2] <= s2v;
            r_b0[1][2] <= row_word.s2r1;
            r_b0[0][2] <= row_word.s2r2;
        end
        r_s2.pix   <= i_adv.pix;
        r_s2.raddr <= i_adv.raddr;
        r_s2.paddr <= i_adv.paddr;
        r_s2.xc    <= i_adv.xc;
        r_s2.yc    <= i_adv.yc;
        r_s2.zc    <= i_adv.zc;
        r_s2.last  <= i_adv.last;
        r_s3.pix   <= '0;
        r_s3.raddr <= '0;
        r_s3.paddr <= '0;
        r_s3.xc    <= r_s2.xc;
        r_s3.yc    <= r_s2.yc;
        r_s3.zc    <= r_s2.zc;
        r_s3.last  <= r_s2.last;
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0; r_s2.emit <= 1'b0;
            r_s3.valid <= 1'b0; r_s3.emit <= 1'b0;
            r_row_fwd <= 1'b0; r_pl_fwd <= 1'b0;
        end else begin
            r_s2.valid <= i_adv.valid;
            r_s2.emit  <= i_adv.emit;
            r_s3.valid <= r_s2.emit;
            r_s3.emit  <= r_s2.emit;
            r_row_fwd  <= i_adv.valid && r_s2.valid && (i_adv.raddr == r_s2.raddr);
            r_pl_fwd   <= i_adv.valid && r_s2.valid && (i_adv.paddr == r_s2.paddr);
        end
    end

    // Neighbour checks over the window, masked at the image edges.
    always_comb begin
        okx  = {r_s3.xc != i_geom.w - 9'd1, 1'b1, r_s3.xc != 9'd0};
        oky  = {r_s3.yc != i_geom.h - 9'd1, 1'b1, r_s3.yc != 9'd0};
        okz  = {r_s3.zc != i_geom.d - 16'd1, 1'b1, r_s3.zc != 16'd0};
        face = !(&okx) || !(&oky) || !(&okz);
        cb2  = r_w0[1][1][7:0];
        cb3  = r_b1[1][1];
        bg8 = 1'b0; bg4 = 1'b0; df8 = 1'b0; df4 = 1'b0; bg26 = 1'b0; bg6 = 1'b0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                cube[0][r][c] = r_b0[r][c];
                cube[1][r][c] = r_b1[r][c];
                cube[2][r][c] = r_w0[r][c][7:0];
                if (!(r == 1 && c == 1) && oky[r] && okx[c]) begin
                    if (r_w0[r][c][7:0] == 8'd0) begin
                        bg8 = 1'b1;
                        if (r == 1 || c == 1) bg4 = 1'b1;
                    end
                    if (r_w0[r][c] != r_w0[1][1]) begin
                        df8 = 1'b1;
                        if (r == 1 || c == 1) df4 = 1'b1;
                    end
                end
            end
        end
        for (int p = 0; p < 3; p++) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (!(p == 1 && r == 1 && c == 1) && okz[p] && oky[r] && okx[c] &&
                        cube[p][r][c] == 8'd0) begin
                        bg26 = 1'b1;
                        if (int'(p != 1) + int'(r != 1) + int'(c != 1) == 1) bg6 = 1'b1;
                    end
                end
            end
        end
    end

    // Result by mode.
    always_comb begin
        case (i_geom.mode)
            MODE_BIN4: o_res.pixel_out = (cb2 != 8'd0 && bg8) ? {24'd0, cb2} : 32'd0;
            MODE_BIN8: o_res.pixel_out = (cb2 != 8'd0 && bg4) ? {24'd0, cb2} : 32'd0;
            MODE_3D6:  o_res.pixel_out = (cb3 != 8'd0 && (face || bg6)) ? {24'd0, cb3} : 32'd0;
            MODE_3D26: o_res.pixel_out = (cb3 != 8'd0 && (face || bg26)) ? {24'd0, cb3} : 32'd0;
            MODE_LAB4: o_res.pixel_out = df8 ? LABEL_EDGE : 32'd0;
            MODE_LAB8: o_res.pixel_out = df4 ? LABEL_EDGE : 32'd0;
            default:   o_res.pixel_out = r_w0[1][1];
        endcase
        o_res.last  = r_s3.last;
        o_res_valid = r_s3.valid;
        o_pend      = {1'b0, r_s2.emit} + {1'b0, r_s3.emit};
    end

endmodule
`default_nettype wire

>>> rtl/bibe_ofifo.sv
// Output queue that holds results until the downstream side takes them.
`default_nettype none
module bibe_ofifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bibe_pkg::t_out_item i_data,
    input  logic                i_pop,
    output logic                o_valid,
    output bibe_pkg::t_out_item o_data,
    output logic [bibe_pkg::OQ_CW-1:0] o_count
);
    import bibe_pkg::*;

    t_out_item        r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wp, r_rp;
    logic [OQ_CW-1:0] r_cnt;
    logic             pop;

    assign pop     = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 3'd1;
            if (pop) r_rp <= r_rp + 3'd1;
            r_cnt <= r_cnt + {3'd0, i_push} - {3'd0, pop};
        end
    end

endmodule
`default_nettype wire

>>> rtl/binary_image_border_extract.sv
// Top level of the binary image border extractor.
//
//  channel  direction  handshake           payload
//  input    in         i_valid / o_stall   i_in_data  (pixel_value, flush)
//  output   out        o_valid / i_stall   o_out_data (pixel_out, last)
//  config   in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// One item per cycle while the input is not stalled. Images too short to fill the
// window (fewer pixels than the window delay) get one filler advance per missing
// delay slot when their final pixel arrives. The row and plane buffers are each
// read once per cycle and written at most once per cycle.
// Reset is synchronous; buffer contents need no clearing. Input stalls in the cycle
// after reset and after each configuration write, while a short image fills the
// window, and when queued plus in-flight results reach the output queue depth.
`default_nettype none
module binary_image_border_extract #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  bibe_pkg::t_in_item  i_in_data,
    output logic                o_valid,
    input  logic                i_stall,
    output bibe_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data
);
    import bibe_pkg::*;

    localparam int EFF_W = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
    localparam int EFF_H = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;

    logic [2:0]  r_mode;
    logic [8:0]  r_width, r_height;
    logic [15:0] r_planes;
    logic        r_cfg_wait;
    t_geom       r_geom, n_geom;

    t_adv             adv;
    logic             res_valid, credit, pop;
    t_out_item        res;
    logic [1:0]       pend;
    logic [OQ_CW-1:0] fifo_cnt;
    logic [4:0]       occupancy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BIN4; r_width <= 9'd256; r_height <= 9'd256;
            r_planes <= 16'd1; r_cfg_wait <= 1'b1;
        end else begin
            r_cfg_wait <= i_cfg_we;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:   r_mode   <= i_cfg_data[2:0];
                    CFG_WIDTH:  r_width  <= i_cfg_data[8:0];
                    CFG_HEIGHT: r_height <= i_cfg_data[8:0];
                    CFG_PLANES: r_planes <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Clamped geometry, plane size and window delay.
    always_comb begin
        n_geom.mode = r_mode;
        n_geom.is3d = (r_mode == MODE_3D6) || (r_mode == MODE_3D26);
        n_geom.w = (r_width == 9'd0) ? 9'd1 : ((r_width > 9'(EFF_W)) ? 9'(EFF_W) : r_width);
        n_geom.h = (r_height == 9'd0) ? 9'd1 :
                   ((r_height > 9'(EFF_H)) ? 9'(EFF_H) : r_height);
        n_geom.d = !n_geom.is3d ? 16'd1 : ((r_planes == 16'd0) ? 16'd1 : r_planes);
        n_geom.ps = 18'(n_geom.w) * 18'(n_geom.h);
        n_geom.delay = n_geom.is3d ? (19'(n_geom.ps) + 19'(n_geom.w) + 19'd1)
                                   : (19'(n_geom.w) + 19'd1);
    end

    always_ff @(posedge i_clk) begin
        r_geom <= n_geom;
    end

    // Results in flight plus queued ones must fit the output queue.
    assign occupancy = 5'(fifo_cnt) + 5'(pend) + 5'(adv.emit);
    assign credit    = occupancy < 5'(OQ_DEPTH);
    assign pop       = o_valid && !i_stall;

    bibe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_in_data),
        .i_geom     (r_geom),
        .i_credit   (credit),
        .i_cfg_wait (r_cfg_wait),
        .o_adv      (adv)
    );

    bibe_window #(
        .ROW_DEPTH (EFF_W),
        .PL_DEPTH  (EFF_W * EFF_H)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (r_geom),
        .i_adv       (adv),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_pend      (pend)
    );

    bibe_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_pop   (pop),
        .o_valid (o_valid),
        .o_data  (o_out_data),
        .o_count (fifo_cnt)
    );

    // The queue never receives a result while it is full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res_valid && fifo_cnt == 4'(OQ_DEPTH)))
        else $error("output queue overflow");

    // Queued and in-flight results never exceed the queue depth.
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occupancy <= 5'(OQ_DEPTH))
        else $error("result credit exceeded");

    // No transaction is taken in the cycle after a configuration write.
    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_stall)
        else $error("input taken right after configuration write");

endmodule
`default_nettype wire
